@@ sv/clipped_stretch_row_scheduler_macros.svh @@
// Assertion macros shared by the clipped stretch row scheduler.
// Depends on nothing; included by the top level.
`ifndef CLIPPED_STRETCH_ROW_SCHEDULER_MACROS_SVH
`define CLIPPED_STRETCH_ROW_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSSR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cssr assertion failed");

// Next-cycle implication, disabled during reset.
`define CSSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cssr assertion failed");

`endif

@@ sv/cssr_pkg.sv @@
// Package for the clipped stretch row scheduler: widths, codes and the
// command and status structs between controller and datapath. No dependencies.
package cssr_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int DIM_W     = 13;
   localparam int ROW_W     = 12;
   localparam int PROD_W    = 2 * DIM_W;
   localparam int CNT_W     = $clog2(PROD_W);
   localparam int CSR_IDX_W = 3;
   localparam int NXS_W     = DIM_W + 2;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_NEXT  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIP_X     = 3'd0,
      CSR_CLIP_Y     = 3'd1,
      CSR_CLIP_W     = 3'd2,
      CSR_CLIP_H     = 3'd3,
      CSR_DST_WIDTH  = 3'd4,
      CSR_DST_HEIGHT = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ROW   = 2'd2,
      KIND_IDLE  = 2'd3
   } kind_type;

   // Which division the shared datapath is working on.
   typedef enum logic [2:0] {
      PH_W = 3'd0,   // destination width
      PH_X = 3'd1,   // destination left edge
      PH_R = 3'd2,   // first destination row
      PH_M = 3'd3,   // starting step remainder
      PH_S = 3'd4    // row step carry
   } phase_type;

   typedef struct packed {
      logic      capture;
      logic      clip;
      logic      load_prod;
      logic      div_go;
      logic      latch;
      logic      nx_prep;
      logic      nx_keep;
      logic      commit;
      phase_type phase;
      kind_type  kind;
   } ctl_cmd_type;

   typedef struct packed {
      logic func_next;
      logic run_active;
      logic clip_empty;
      logic drow_over;
      logic need_div;
      logic row_end;
      logic div_done;
      logic out_free;
   } ctl_sts_type;

   // Clamp a wide quotient to the largest destination dimension.
   function automatic logic [DIM_W-1:0] sat_dim(input logic [PROD_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = (v > PROD_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v[DIM_W-1:0];
      return r;
   endfunction

endpackage

@@ sv/cssr_if.sv @@
// Channel interfaces of the clipped stretch row scheduler: request, response
// and register write channels. Depends on cssr_pkg.
interface cssr_req_if;
   import cssr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    func;
   logic signed [DIM_W-1:0] rect_x;
   logic signed [DIM_W-1:0] rect_y;
   logic [DIM_W-1:0]        rect_w;
   logic [DIM_W-1:0]        rect_h;
   modport source(output valid, func, rect_x, rect_y, rect_w, rect_h, input ready);
   modport sink(input valid, func, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface cssr_rsp_if;
   import cssr_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       kind;
   logic [ROW_W-1:0] src_row;
   logic [ROW_W-1:0] dst_row;
   logic [DIM_W-1:0] dest_x;
   logic [DIM_W-1:0] dest_w;
   logic [DIM_W-1:0] rows_done;
   logic             last;
   modport source(output valid, kind, src_row, dst_row, dest_x, dest_w, rows_done, last,
                  input ready);
   modport sink(input valid, kind, src_row, dst_row, dest_x, dest_w, rows_done, last,
                output ready);
endinterface

interface cssr_csr_if;
   import cssr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

@@ sv/cssr_div.sv @@
// Restoring divider, one quotient bit per cycle, for the scheduler datapath.
// Depends on cssr_pkg.
module cssr_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cssr_pkg::PROD_W-1:0]  dividend,
   input  logic [cssr_pkg::DIM_W-1:0]   divisor,
   output logic [cssr_pkg::PROD_W-1:0]  quo,
   output logic [cssr_pkg::DIM_W-1:0]   rem,
   output logic                         done
);
   import cssr_pkg::*;

   logic [PROD_W-1:0] quo_ff;
   logic [DIM_W-1:0]  rem_ff;
   logic [DIM_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIM_W:0]    trial;
   logic              fits;

   // One trial subtraction of the shifted partial remainder.
   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath of the shift-subtract loop.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[PROD_W-2:0], fits};
         rem_ff <= fits ? DIM_W'(trial - {1'b0, dvs_ff}) : trial[DIM_W-1:0];
      end
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign done = done_ff;
endmodule

@@ sv/cssr_dp.sv @@
// Datapath of the scheduler: registers, clipping, multiplier, divider, run
// state and the response register. Depends on cssr_pkg, cssr_if and cssr_div.
module cssr_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  cssr_pkg::ctl_cmd_type cmd,
   output cssr_pkg::ctl_sts_type sts,
   cssr_req_if.sink              req_ch,
   cssr_rsp_if.source            rsp_ch,
   cssr_csr_if.sink              csr_ch
);
   import cssr_pkg::*;

   // Configuration registers.
   logic [ROW_W-1:0] clip_x_ff, clip_y_ff;
   logic [DIM_W-1:0] clip_w_ff, clip_h_ff, dst_width_ff, dst_height_ff;

   // Captured word and clipped rectangle.
   logic                    func_ff;
   logic signed [DIM_W-1:0] rect_x_ff, rect_y_ff;
   logic [DIM_W-1:0]        rect_w_ff, rect_h_ff;
   logic [DIM_W-1:0]        dxrel_ff, cw2_ff, rel_ff, ch2_ff;
   logic                    empty_ff;

   // Start results.
   logic [PROD_W-1:0] prod_ff;
   logic [DIM_W-1:0]  dw_ff, dx_ff, drow_ff, r1_ff, srem_ff;

   // Row step working values.
   logic [DIM_W-1:0] nx_dst_ff, nx_rem_ff;
   logic [DIM_W:0]   nx_sum_ff;
   logic [NXS_W-1:0] nx_src_ff;

   // Run state.
   logic             run_active_ff;
   logic [DIM_W-1:0] cur_src_rel_ff, end_src_rel_ff, cur_dst_row_ff;
   logic [DIM_W-1:0] step_rem_ff, start_dst_row_ff, saved_dest_x_ff, saved_dest_w_ff;

   // Response register.
   logic             rsp_valid_ff;
   logic [1:0]       kind_ff;
   logic [ROW_W-1:0] src_row_ff, dst_row_ff;
   logic [DIM_W-1:0] dest_x_ff, dest_w_ff, rows_done_ff;
   logic             last_ff;

   // Clipping against the window in a signed 16-bit frame.
   logic signed [15:0] x_s, y_s, w_s, h_s, cx_s, cy_s, cw_s, ch_s;
   logic signed [15:0] x1, y1, w1, h1, w2, h2, xlim, ylim;
   logic               disjoint, empty;

   always_comb begin
      x_s  = {{3{rect_x_ff[DIM_W-1]}}, rect_x_ff};
      y_s  = {{3{rect_y_ff[DIM_W-1]}}, rect_y_ff};
      w_s  = {3'b000, rect_w_ff};
      h_s  = {3'b000, rect_h_ff};
      cx_s = {4'b0000, clip_x_ff};
      cy_s = {4'b0000, clip_y_ff};
      cw_s = {3'b000, clip_w_ff};
      ch_s = {3'b000, clip_h_ff};
      disjoint = (x_s > cx_s + cw_s) || (x_s + w_s < cx_s) ||
                 (y_s > cy_s + ch_s) || (y_s + h_s < cy_s);
      x1   = (x_s < cx_s) ? cx_s : x_s;
      w1   = (x_s < cx_s) ? w_s - (cx_s - x_s) : w_s;
      xlim = cx_s + cw_s - x1;
      w2   = (w1 > xlim) ? xlim : w1;
      y1   = (y_s < cy_s) ? cy_s : y_s;
      h1   = (y_s < cy_s) ? h_s - (cy_s - y_s) : h_s;
      ylim = cy_s + ch_s - y1;
      h2   = (h1 > ylim) ? ylim : h1;
      empty = (clip_w_ff == '0) || (clip_h_ff == '0) || (dst_height_ff == '0) ||
              disjoint || (w2 <= 16'sd0) || (h2 <= 16'sd0);
   end

   // Operand selection for the multiplier and the divider.
   logic [DIM_W-1:0]  mul_a, mul_b, mul_c, dvs;
   logic [PROD_W-1:0] mul_p, prod_in;

   always_comb begin
      case (cmd.phase)
         PH_W: begin
            mul_a = cw2_ff;  mul_b = dst_width_ff;  mul_c = '0;
            dvs   = clip_w_ff;
         end
         PH_X: begin
            mul_a = dxrel_ff; mul_b = dst_width_ff; mul_c = '0;
            dvs   = clip_w_ff;
         end
         PH_R: begin
            mul_a = rel_ff;  mul_b = dst_height_ff; mul_c = clip_h_ff - DIM_W'(1);
            dvs   = clip_h_ff;
         end
         default: begin
            mul_a = '0;      mul_b = '0;            mul_c = '0;
            dvs   = dst_height_ff;
         end
      endcase
      mul_p = {{DIM_W{1'b0}}, mul_a} * {{DIM_W{1'b0}}, mul_b};
      case (cmd.phase)
         PH_M:    prod_in = PROD_W'(clip_h_ff - DIM_W'(1) - r1_ff);
         PH_S:    prod_in = PROD_W'(nx_sum_ff);
         default: prod_in = mul_p + PROD_W'(mul_c);
      endcase
   end

   logic [PROD_W-1:0] div_quo;
   logic [DIM_W-1:0]  div_rem;
   logic              div_done;

   cssr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (prod_ff),
      .divisor  (dvs),
      .quo      (div_quo),
      .rem      (div_rem),
      .done     (div_done)
   );

   // Row pair outcome and count.
   logic             row_end, row_done;
   logic [DIM_W-1:0] rows_diff, rows_sat;

   always_comb begin
      row_end   = (nx_dst_ff >= dst_height_ff);
      row_done  = row_end || (nx_src_ff >= NXS_W'(end_src_rel_ff));
      rows_diff = nx_dst_ff - start_dst_row_ff;
      rows_sat  = (rows_diff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_diff;
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Fields of the word that a commit loads; unused fields stay zero.
   logic [ROW_W-1:0] src_row_in, dst_row_in;
   logic [DIM_W-1:0] dest_x_in, dest_w_in, rows_done_in;
   logic             last_in;

   always_comb begin
      src_row_in   = '0;
      dst_row_in   = '0;
      dest_x_in    = '0;
      dest_w_in    = '0;
      rows_done_in = '0;
      last_in      = 1'b0;
      case (cmd.kind)
         KIND_START: begin
            src_row_in = clip_y_ff + rel_ff[ROW_W-1:0];
            dst_row_in = drow_ff[ROW_W-1:0];
            dest_x_in  = dx_ff;
            dest_w_in  = dw_ff;
         end
         KIND_ROW: begin
            src_row_in   = clip_y_ff + cur_src_rel_ff[ROW_W-1:0];
            dst_row_in   = cur_dst_row_ff[ROW_W-1:0];
            dest_x_in    = saved_dest_x_ff;
            dest_w_in    = saved_dest_w_ff;
            rows_done_in = rows_sat;
            last_in      = row_done;
         end
         default: ;
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_x_ff     <= '0;
         clip_y_ff     <= '0;
         clip_w_ff     <= DIM_W'(640);
         clip_h_ff     <= DIM_W'(480);
         dst_width_ff  <= DIM_W'(640);
         dst_height_ff <= DIM_W'(480);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_CLIP_X:     clip_x_ff     <= csr_ch.data[ROW_W-1:0];
            CSR_CLIP_Y:     clip_y_ff     <= csr_ch.data[ROW_W-1:0];
            CSR_CLIP_W:     clip_w_ff     <= csr_ch.data;
            CSR_CLIP_H:     clip_h_ff     <= csr_ch.data;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_ch.data;
            CSR_DST_HEIGHT: dst_height_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Working registers of the start and row step sequences.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_ch.func;
         rect_x_ff <= req_ch.rect_x;
         rect_y_ff <= req_ch.rect_y;
         rect_w_ff <= req_ch.rect_w;
         rect_h_ff <= req_ch.rect_h;
      end
      if (cmd.clip) begin
         dxrel_ff <= DIM_W'(x1 - cx_s);
         cw2_ff   <= DIM_W'(w2);
         rel_ff   <= DIM_W'(y1 - cy_s);
         ch2_ff   <= DIM_W'(h2);
         empty_ff <= empty;
      end
      if (cmd.load_prod) begin
         prod_ff <= prod_in;
      end
      if (cmd.latch) begin
         case (cmd.phase)
            PH_W: dw_ff <= sat_dim(div_quo);
            PH_X: dx_ff <= sat_dim(div_quo);
            PH_R: begin
               drow_ff <= div_quo[DIM_W-1:0];
               r1_ff   <= div_rem;
            end
            PH_M: srem_ff <= div_rem;
            PH_S: begin
               nx_rem_ff <= div_rem;
               nx_src_ff <= NXS_W'(cur_src_rel_ff) + div_quo[NXS_W-1:0];
            end
            default: ;
         endcase
      end
      if (cmd.nx_prep) begin
         nx_dst_ff <= cur_dst_row_ff + DIM_W'(1);
         nx_sum_ff <= {1'b0, step_rem_ff} + {1'b0, clip_h_ff};
      end
      if (cmd.nx_keep) begin
         nx_rem_ff <= nx_sum_ff[DIM_W-1:0];
         nx_src_ff <= NXS_W'(cur_src_rel_ff);
      end
   end

   // Run state and response register, loaded on a commit; valid clears on a take.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         run_active_ff    <= 1'b0;
         cur_src_rel_ff   <= '0;
         end_src_rel_ff   <= '0;
         cur_dst_row_ff   <= '0;
         step_rem_ff      <= '0;
         start_dst_row_ff <= '0;
         saved_dest_x_ff  <= '0;
         saved_dest_w_ff  <= '0;
      end else begin
         // A commit only happens into a free register, so it wins over the take.
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.commit) begin
            kind_ff      <= cmd.kind;
            src_row_ff   <= src_row_in;
            dst_row_ff   <= dst_row_in;
            dest_x_ff    <= dest_x_in;
            dest_w_ff    <= dest_w_in;
            rows_done_ff <= rows_done_in;
            last_ff      <= last_in;
            case (cmd.kind)
               KIND_START: begin
                  run_active_ff    <= 1'b1;
                  cur_src_rel_ff   <= rel_ff;
                  end_src_rel_ff   <= rel_ff + ch2_ff;
                  cur_dst_row_ff   <= drow_ff;
                  step_rem_ff      <= srem_ff;
                  start_dst_row_ff <= drow_ff;
                  saved_dest_x_ff  <= dx_ff;
                  saved_dest_w_ff  <= dw_ff;
               end
               KIND_EMPTY: begin
                  run_active_ff <= 1'b0;
               end
               KIND_ROW: begin
                  run_active_ff  <= !row_done;
                  cur_dst_row_ff <= nx_dst_ff;
                  step_rem_ff    <= nx_rem_ff;
                  cur_src_rel_ff <= nx_src_ff[DIM_W-1:0];
               end
               default: ;
            endcase
         end
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.func_next  = (func_ff == FUNC_NEXT);
      sts.run_active = run_active_ff;
      sts.clip_empty = empty_ff;
      sts.drow_over  = (drow_ff >= dst_height_ff);
      sts.need_div   = (nx_sum_ff >= {1'b0, dst_height_ff});
      sts.row_end    = row_end;
      sts.div_done   = div_done;
      sts.out_free   = out_free;
   end

   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.kind      = kind_ff;
   assign rsp_ch.src_row   = src_row_ff;
   assign rsp_ch.dst_row   = dst_row_ff;
   assign rsp_ch.dest_x    = dest_x_ff;
   assign rsp_ch.dest_w    = dest_w_ff;
   assign rsp_ch.rows_done = rows_done_ff;
   assign rsp_ch.last      = last_ff;
endmodule

@@ sv/cssr_ctrl.sv @@
// Controller of the scheduler: sequences clipping, the four start divisions
// and the row step, and commits each result. Depends on cssr_pkg.
module cssr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cssr_pkg::ctl_sts_type sts,
   output cssr_pkg::ctl_cmd_type cmd
);
   import cssr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_CLIP, S_MUL, S_GO, S_WAIT, S_NXPREP, S_NXCHK, S_OUT
   } state_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   kind_type  kind_ff, kind_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.phase = phase_ff;
      cmd.kind  = kind_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_CLIP;
            end
         end
         S_CLIP: begin
            if (sts.func_next) begin
               state_in = S_NXPREP;
            end else begin
               cmd.clip = 1'b1;
               phase_in = PH_W;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if ((phase_ff == PH_W && sts.clip_empty) ||
                (phase_ff == PH_M && sts.drow_over)) begin
               kind_in  = KIND_EMPTY;
               state_in = S_OUT;
            end else begin
               cmd.load_prod = 1'b1;
               state_in      = S_GO;
            end
         end
         S_GO: begin
            cmd.div_go = 1'b1;
            state_in   = S_WAIT;
         end
         S_WAIT: begin
            if (sts.div_done) begin
               cmd.latch = 1'b1;
               case (phase_ff)
                  PH_W: begin phase_in = PH_X; state_in = S_MUL; end
                  PH_X: begin phase_in = PH_R; state_in = S_MUL; end
                  PH_R: begin phase_in = PH_M; state_in = S_MUL; end
                  PH_M: begin kind_in = KIND_START; state_in = S_OUT; end
                  default: begin kind_in = KIND_ROW; state_in = S_OUT; end
               endcase
            end
         end
         S_NXPREP: begin
            if (!sts.run_active) begin
               kind_in  = KIND_IDLE;
               state_in = S_OUT;
            end else begin
               cmd.nx_prep = 1'b1;
               state_in    = S_NXCHK;
            end
         end
         S_NXCHK: begin
            if (sts.need_div && !sts.row_end) begin
               phase_in = PH_S;
               state_in = S_MUL;
            end else begin
               cmd.nx_keep = 1'b1;
               kind_in     = KIND_ROW;
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_W;
         kind_ff  <= KIND_IDLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
endmodule

@@ sv/clipped_stretch_row_scheduler.sv @@
// Clipped stretch row scheduler, top level.
// req_ch takes one word at a time: func 0 starts a rectangle (clipped to the
// clip window, then scaled to the destination), func 1 asks for the next
// source/destination row pair. rsp_ch returns exactly one word per request.
// csr_ch writes the six window and destination registers; it is always
// ready and must only be used while no request is in flight.
// An accepted start word runs four divisions on one shared restoring divider,
// each with operand load, launch, the quotient steps and the done handoff,
// plus clipping and commit. An empty start leaves early. A row request
// needs the divider only when the row step carries past the destination
// height; a row request with no run active skips the row step.
// One request is worked on at a time; req_ch.ready returns once the result
// sits in the response register, so the next word is taken while the
// receiver still holds off. A stalled response holds its word and blocks
// the following result until it is taken.
// Reset is synchronous; it loads the register defaults and ends any run.
// Depends on cssr_pkg, cssr_if, cssr_ctrl, cssr_dp and the macro header.
module clipped_stretch_row_scheduler (
   input  logic        clock,
   input  logic        reset,
   cssr_req_if.sink    req_ch,
   cssr_rsp_if.source  rsp_ch,
   cssr_csr_if.sink    csr_ch
);
   import cssr_pkg::*;
   `include "clipped_stretch_row_scheduler_macros.svh"

   ctl_cmd_type cmd;
   ctl_sts_type sts;
   logic        ctl_req_ready;

   cssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctl_req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cssr_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   assign req_ch.ready = ctl_req_ready;

   // A result is only committed into a free response register.
   `CSSR_ASSERT_NOW(a_commit_free, clock, reset, cmd.commit, sts.out_free)
   // An accepted word never produces its result in the following cycle.
   `CSSR_ASSERT_NEXT(a_no_instant, clock, reset, req_ch.valid && req_ch.ready, !cmd.commit)
   // The divider cannot finish right after it is started.
   `CSSR_ASSERT_NEXT(a_div_latency, clock, reset, cmd.div_go, !sts.div_done)
endmodule
